// ===== rtl/core/bsap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsap_pkg: shared types and constants of the bulk string array parser
// Result kinds, error codes, marker bytes and the result record that the
// parse stage hands to the output register.
// ----------------------------------------------------------------------------
package bsap_pkg;

	localparam int ArgIdxW  = 10;
	localparam int ByteIdxW = 29;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_END   = 2'd1,
		KIND_EMPTY = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NO_ARRAY = 3'd0,
		ERR_NO_BULK  = 3'd1,
		ERR_BAD_NUM  = 3'd2,
		ERR_RANGE    = 3'd3,
		ERR_NO_CRLF  = 3'd4
	} err_t;

	localparam logic [7:0] CHR_STAR  = 8'h2A;
	localparam logic [7:0] CHR_DOLL  = 8'h24;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;

	typedef struct packed {
		logic                valid;
		kind_t               kind;
		logic [7:0]          arg_byte;
		logic [ArgIdxW-1:0]  arg_index;
		logic [ByteIdxW-1:0] byte_index;
		logic                last_arg;
		err_t                error_code;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/bsap_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsap_parser: parse state machine
// Holds phase, number accumulator and argument counters; decodes one byte
// per fire and presents the result of that byte combinationally.
// ----------------------------------------------------------------------------
module bsap_parser
	import bsap_pkg::*;
#(
	parameter int MAX_ARGS     = 1024,
	parameter int MAX_BULK_LEN = 536870912
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] data_byte,
	input  wire logic       restart,
	output result_t         rslt
);

	localparam int CNT_W = $clog2(MAX_ARGS + 1);
	localparam int LEN_W = $clog2(MAX_BULK_LEN + 1);
	localparam int ACC_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int VAL_W = ACC_W + 4;
	localparam logic [VAL_W-1:0] ARGS_LIM = VAL_W'(MAX_ARGS);
	localparam logic [VAL_W-1:0] LEN_LIM  = VAL_W'(MAX_BULK_LEN);

	typedef enum logic [3:0] {
		PH_START, PH_COUNT, PH_COUNT_LF, PH_MARK, PH_LEN,
		PH_LEN_LF, PH_DATA, PH_DATA_LF, PH_FAILED
	} phase_t;

	phase_t             phase_q,    phase_n;
	logic [ACC_W-1:0]   acc_q,      acc_n;
	logic               neg_q,      neg_n;
	logic               seen_q,     seen_n;
	logic [CNT_W-1:0]   exp_q,      exp_n;
	logic [CNT_W-1:0]   rcv_q,      rcv_n;
	logic [LEN_W-1:0]   blen_q,     blen_n;
	logic [LEN_W-1:0]   bseen_q,    bseen_n;

	logic [VAL_W-1:0]   num_val;
	logic [VAL_W-1:0]   num_lim;
	logic               is_digit;
	logic               num_err;
	err_t               num_code;
	logic [CNT_W:0]     rcv_inc;

	// acc*10 + digit as shift-add
	assign is_digit = (data_byte >= CHR_ZERO) && (data_byte <= CHR_NINE);
	assign num_val  = (VAL_W'(acc_q) << 3) + (VAL_W'(acc_q) << 1)
		+ VAL_W'(data_byte[3:0]);
	assign num_lim  = (phase_q == PH_COUNT) ? ARGS_LIM : LEN_LIM;
	assign rcv_inc  = {1'b0, rcv_q} + (CNT_W + 1)'(1);

	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		seen_n   = seen_q;
		exp_n    = exp_q;
		rcv_n    = rcv_q;
		blen_n   = blen_q;
		bseen_n  = bseen_q;
		num_err  = 1'b0;
		num_code = ERR_BAD_NUM;

		rslt            = '0;
		rslt.kind       = KIND_BYTE;
		rslt.error_code = ERR_NO_ARRAY;

		// number line byte, shared by count and length; only on number lines
		if (phase_q == PH_COUNT || phase_q == PH_LEN) begin
			if (data_byte == CHR_MINUS) begin
				if (seen_q || neg_q) begin
					num_err = 1'b1;
				end else begin
					neg_n = 1'b1;
				end
			end else if (is_digit) begin
				if ((neg_q && num_val != '0) || num_val > num_lim) begin
					num_err  = 1'b1;
					num_code = ERR_RANGE;
				end else begin
					acc_n  = num_val[ACC_W-1:0];
					seen_n = 1'b1;
				end
			end else if (data_byte == CHR_CR) begin
				if (!seen_q) begin
					num_err = 1'b1;
				end else begin
					phase_n = (phase_q == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
				end
			end else begin
				num_err = 1'b1;
			end
		end

		if (restart) begin
			phase_n = PH_START;
			acc_n   = '0;
			neg_n   = 1'b0;
			seen_n  = 1'b0;
			exp_n   = '0;
			rcv_n   = '0;
			blen_n  = '0;
			bseen_n = '0;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (data_byte != CHR_STAR) begin
						rslt.valid      = 1'b1;
						rslt.kind       = KIND_ERROR;
						rslt.error_code = ERR_NO_ARRAY;
						phase_n         = PH_FAILED;
					end else begin
						acc_n   = '0;
						neg_n   = 1'b0;
						seen_n  = 1'b0;
						phase_n = PH_COUNT;
					end
				end
				PH_COUNT, PH_LEN: begin
					if (num_err) begin
						rslt.valid      = 1'b1;
						rslt.kind       = KIND_ERROR;
						rslt.error_code = num_code;
						phase_n         = PH_FAILED;
					end
				end
				PH_COUNT_LF: begin
					if (data_byte != CHR_LF) begin
						rslt.valid      = 1'b1;
						rslt.kind       = KIND_ERROR;
						rslt.error_code = ERR_NO_CRLF;
						phase_n         = PH_FAILED;
					end else if (acc_q == '0) begin
						rcv_n      = '0;
						exp_n      = '0;
						phase_n    = PH_START;
						rslt.valid = 1'b1;
						rslt.kind  = KIND_EMPTY;
					end else begin
						rcv_n   = '0;
						exp_n   = acc_q[CNT_W-1:0];
						phase_n = PH_MARK;
					end
				end
				PH_MARK: begin
					if (data_byte != CHR_DOLL) begin
						rslt.valid      = 1'b1;
						rslt.kind       = KIND_ERROR;
						rslt.error_code = ERR_NO_BULK;
						phase_n         = PH_FAILED;
					end else begin
						acc_n   = '0;
						neg_n   = 1'b0;
						seen_n  = 1'b0;
						phase_n = PH_LEN;
					end
				end
				PH_LEN_LF: begin
					if (data_byte != CHR_LF) begin
						rslt.valid      = 1'b1;
						rslt.kind       = KIND_ERROR;
						rslt.error_code = ERR_NO_CRLF;
						phase_n         = PH_FAILED;
					end else begin
						blen_n  = acc_q[LEN_W-1:0];
						bseen_n = '0;
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					if (bseen_q < blen_q) begin
						bseen_n         = bseen_q + LEN_W'(1);
						rslt.valid      = 1'b1;
						rslt.kind       = KIND_BYTE;
						rslt.arg_byte   = data_byte;
						rslt.arg_index  = ArgIdxW'(rcv_q);
						rslt.byte_index = ByteIdxW'(bseen_q);
					end else if (data_byte != CHR_CR) begin
						rslt.valid      = 1'b1;
						rslt.kind       = KIND_ERROR;
						rslt.error_code = ERR_NO_CRLF;
						phase_n         = PH_FAILED;
					end else begin
						phase_n = PH_DATA_LF;
					end
				end
				PH_DATA_LF: begin
					if (data_byte != CHR_LF) begin
						rslt.valid      = 1'b1;
						rslt.kind       = KIND_ERROR;
						rslt.error_code = ERR_NO_CRLF;
						phase_n         = PH_FAILED;
					end else begin
						rslt.valid     = 1'b1;
						rslt.kind      = KIND_END;
						rslt.arg_index = ArgIdxW'(rcv_q);
						if (rcv_inc >= {1'b0, exp_q}) begin
							// command complete: back to start, counts cleared
							rslt.last_arg = 1'b1;
							phase_n       = PH_START;
							acc_n         = '0;
							neg_n         = 1'b0;
							seen_n        = 1'b0;
							exp_n         = '0;
							rcv_n         = '0;
							blen_n        = '0;
							bseen_n       = '0;
						end else begin
							rcv_n   = rcv_inc[CNT_W-1:0];
							phase_n = PH_MARK;
						end
					end
				end
				default: begin
					phase_n = PH_FAILED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			exp_q   <= '0;
			rcv_q   <= '0;
			blen_q  <= '0;
			bseen_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			seen_q  <= seen_n;
			exp_q   <= exp_n;
			rcv_q   <= rcv_n;
			blen_q  <= blen_n;
			bseen_q <= bseen_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bulk_string_array_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bulk_string_array_parser: command stream parser, one byte per beat
// Parses '*' count CRLF then per argument '$' length CRLF data CRLF and
// reports data bytes with their positions, argument ends and errors.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  cmd      | cmd_valid, cmd_stall | data_byte, restart
//  res      | res_valid, res_stall | kind, arg_byte, arg_index, byte_index,
//           |                      | last_arg, error_code
//
//  Each byte passes through the input register (_s1), then the parse state
//  machine and the result register (_s2). One beat per cycle unless stalled.
//  A byte that yields no result (markers, digits, CRLF) still passes through
//  but produces no res beat.
//  Reset puts the parser at start, waiting for '*', with all counts cleared.
//  res_stall holds a full result register; the input register then holds
//  too, and cmd_stall rises only while it holds a byte that cannot move on.
//  After an error the parser drops every byte until one arrives with restart.
//
module bulk_string_array_parser
	import bsap_pkg::*;
#(
	parameter int MAX_ARGS     = 1024,
	parameter int MAX_BULK_LEN = 536870912
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// command byte stream
	input  wire logic                cmd_valid,
	output      logic                cmd_stall,
	input  wire logic [7:0]          data_byte,
	input  wire logic                restart,
	// parse results
	output      logic                res_valid,
	input  wire logic                res_stall,
	output      logic [1:0]          kind,
	output      logic [7:0]          arg_byte,
	output      logic [ArgIdxW-1:0]  arg_index,
	output      logic [ByteIdxW-1:0] byte_index,
	output      logic                last_arg,
	output      logic [2:0]          error_code
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;

	logic       advance;
	logic       fire;
	result_t    rslt;

	logic       valid_s2;
	result_t    rslt_s2;

	// result register free, or being drained this cycle
	assign advance   = !valid_s2 || !res_stall;
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall) begin
			byte_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	bsap_parser #(
		.MAX_ARGS     (MAX_ARGS),
		.MAX_BULK_LEN (MAX_BULK_LEN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.rslt      (rslt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && rslt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rslt_s2 <= rslt;
		end
	end

	assign res_valid  = valid_s2;
	assign kind       = rslt_s2.kind;
	assign arg_byte   = rslt_s2.arg_byte;
	assign arg_index  = rslt_s2.arg_index;
	assign byte_index = rslt_s2.byte_index;
	assign last_arg   = rslt_s2.last_arg;
	assign error_code = rslt_s2.error_code;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bulk_string_array_parser
// Feeds command byte streams (directed corner cases, then random commands,
// some of them damaged), predicts every result beat with a behavioral
// parser kept in step with the accepted input, and checks the result channel
// field by field under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import bsap_pkg::*;

	localparam longint unsigned ARG_LIMIT = 1024;
	localparam longint unsigned LEN_LIMIT = 536870912;
	localparam int RANDOM_BEATS = 400;  // command beats in the random part
	localparam int SEG_BEATS    = 128;  // accepted beats per idling segment
	localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 20;   // settle time after the last result
	localparam int WATCHDOG_MAX = 1000; // cycles without any beat

	// error_code reads 0 unless the kind is an error
	localparam err_t ERR_NONE = ERR_NO_ARRAY;

	typedef enum logic [3:0] {
		ST_START,
		ST_COUNT,
		ST_COUNT_LF,
		ST_MARK,
		ST_LEN,
		ST_LEN_LF,
		ST_DATA,
		ST_DATA_LF,
		ST_FAILED
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       rst;
	} cmd_item_t;

	typedef struct packed {
		kind_t               kind;
		logic [7:0]          data;
		logic [ArgIdxW-1:0]  arg;
		logic [ByteIdxW-1:0] pos;
		logic                last;
		err_t                err;
	} parse_result_t;

	// ------------------------------------------------------------------------
	// DUT hookup; every input has a known value from time zero
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	logic [7:0]          data_byte = 8'h00;
	logic                restart   = 1'b0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [1:0]          kind;
	logic [7:0]          arg_byte;
	logic [ArgIdxW-1:0]  arg_index;
	logic [ByteIdxW-1:0] byte_index;
	logic                last_arg;
	logic [2:0]          error_code;

	bulk_string_array_parser u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.data_byte  (data_byte),
		.restart    (restart),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.arg_byte   (arg_byte),
		.arg_index  (arg_index),
		.byte_index (byte_index),
		.last_arg   (last_arg),
		.error_code (error_code)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------------
	cmd_item_t     byte_stream[$];  // beats still to be offered
	parse_result_t results_due[$];  // predicted result beats, oldest first
	logic [7:0]    scratch[$];      // command under construction
	bit            broken;          // scratch command will end in an error

	int cmd_beats   = 0;  // accepted command beats
	int issued      = 0;  // command beats put on the wires
	int mismatches  = 0;
	int quiet_count = 0;
	int hold_left   = 0;
	bit held_once   = 1'b0;

	// shadow of the parser state
	parse_phase_t    ph;
	longint unsigned num_acc;
	bit              num_neg;
	bit              num_seen;
	logic [10:0]     args_want;
	logic [10:0]     args_got;
	longint unsigned blk_len;
	longint unsigned blk_seen;

	// ------------------------------------------------------------------------
	// Parser prediction
	// ------------------------------------------------------------------------
	function automatic void push_result(kind_t k, logic [7:0] d, longint unsigned a,
			longint unsigned p, logic l, err_t e);
		parse_result_t r;
		r.kind = k;
		r.data = d;
		r.arg  = a[ArgIdxW-1:0];
		r.pos  = p[ByteIdxW-1:0];
		r.last = l;
		r.err  = e;
		results_due.push_back(r);
	endfunction

	function automatic void clear_number();
		num_acc  = 0;
		num_neg  = 1'b0;
		num_seen = 1'b0;
	endfunction

	function automatic void clear_parser();
		ph = ST_START;
		clear_number();
		args_want = '0;
		args_got  = '0;
		blk_len   = 0;
		blk_seen  = 0;
	endfunction

	// parser goes silent until restart
	function automatic void flag_error(err_t e);
		ph = ST_FAILED;
		push_result(KIND_ERROR, 8'h00, 0, 0, 1'b0, e);
	endfunction

	// one byte of a decimal line; returns 1 with the error code on a fault
	function automatic bit number_step(logic [7:0] c, longint unsigned limit,
			parse_phase_t nxt, output err_t code);
		longint unsigned v;
		code = ERR_BAD_NUM;
		if (c == CHR_MINUS) begin
			if (num_seen || num_neg)
				return 1'b1;
			num_neg = 1'b1;
			return 1'b0;
		end
		if (c >= CHR_ZERO && c <= CHR_NINE) begin
			v = num_acc * 10 + longint'(c - CHR_ZERO);
			// range is checked digit by digit; "-0" stays legal
			if ((num_neg && v != 0) || v > limit) begin
				code = ERR_RANGE;
				return 1'b1;
			end
			num_acc  = v;
			num_seen = 1'b1;
			return 1'b0;
		end
		if (c == CHR_CR && num_seen) begin
			ph = nxt;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void parse_byte(logic [7:0] c, logic rst);
		err_t            code;
		logic [10:0]     idx;
		if (rst) begin
			clear_parser();
			return;
		end
		case (ph)
			ST_START: begin
				if (c != CHR_STAR)
					flag_error(ERR_NO_ARRAY);
				else begin
					clear_number();
					ph = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (number_step(c, ARG_LIMIT, ST_COUNT_LF, code))
					flag_error(code);
			end
			ST_COUNT_LF: begin
				if (c != CHR_LF)
					flag_error(ERR_NO_CRLF);
				else begin
					args_got = '0;
					if (num_acc == 0) begin
						// empty command completes right away
						args_want = '0;
						ph = ST_START;
						push_result(KIND_EMPTY, 8'h00, 0, 0, 1'b0, ERR_NONE);
					end else begin
						args_want = num_acc[10:0];
						ph = ST_MARK;
					end
				end
			end
			ST_MARK: begin
				if (c != CHR_DOLL)
					flag_error(ERR_NO_BULK);
				else begin
					clear_number();
					ph = ST_LEN;
				end
			end
			ST_LEN: begin
				if (number_step(c, LEN_LIMIT, ST_LEN_LF, code))
					flag_error(code);
			end
			ST_LEN_LF: begin
				if (c != CHR_LF)
					flag_error(ERR_NO_CRLF);
				else begin
					blk_len  = num_acc;
					blk_seen = 0;
					ph = ST_DATA;
				end
			end
			ST_DATA: begin
				if (blk_seen < blk_len) begin
					push_result(KIND_BYTE, c, args_got, blk_seen, 1'b0, ERR_NONE);
					blk_seen++;
				end else if (c != CHR_CR)
					flag_error(ERR_NO_CRLF);
				else
					ph = ST_DATA_LF;
			end
			ST_DATA_LF: begin
				if (c != CHR_LF)
					flag_error(ERR_NO_CRLF);
				else begin
					idx = args_got;
					args_got++;
					if (args_got >= args_want) begin
						clear_parser();
						push_result(KIND_END, 8'h00, idx, 0, 1'b1, ERR_NONE);
					end else begin
						ph = ST_MARK;
						push_result(KIND_END, 8'h00, idx, 0, 1'b0, ERR_NONE);
					end
				end
			end
			default: ;  // failed: drop everything
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus building: bytes collect in scratch, flush moves them out
	// ------------------------------------------------------------------------
	function automatic void put_byte(logic [7:0] b);
		scratch.push_back(b);
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			scratch.push_back(s[i]);
	endfunction

	function automatic void put_crlf();
		scratch.push_back(CHR_CR);
		scratch.push_back(CHR_LF);
	endfunction

	function automatic void put_line(string s);
		put_str(s);
		put_crlf();
	endfunction

	function automatic void push_restart();
		cmd_item_t it;
		it.data = 8'($urandom_range(255));
		it.rst  = 1'b1;
		byte_stream.push_back(it);
	endfunction

	function automatic void push_data(logic [7:0] b);
		cmd_item_t it;
		it.data = b;
		it.rst  = 1'b0;
		byte_stream.push_back(it);
	endfunction

	function automatic void flush(bit then_restart);
		while (scratch.size() > 0)
			push_data(scratch.pop_front());
		if (then_restart)
			push_restart();
	endfunction

	// decimal with occasional leading zero, "-0", or an out-of-range value
	function automatic void put_num(longint unsigned n, longint unsigned limit);
		int r;
		r = $urandom_range(39);
		if (r == 0) begin
			broken = 1'b1;
			if ($urandom_range(1))
				put_str($sformatf("-%0d", n + 1));
			else
				put_str($sformatf("%0d", limit + 1 + $urandom_range(1000)));
			return;
		end
		if (r < 4)
			put_byte(CHR_ZERO);
		if (n == 0 && r >= 4 && r < 8)
			put_byte(CHR_MINUS);
		put_str($sformatf("%0d", n));
	endfunction

	// one random command; most are well formed, some get damaged
	function automatic void gen_command();
		int n_args;
		int len;
		int r;
		int pos;
		broken = 1'b0;
		n_args = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
		put_byte(CHR_STAR);
		put_num(n_args, ARG_LIMIT);
		put_crlf();
		for (int i = 0; i < n_args; i++) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 5);
			put_byte(CHR_DOLL);
			put_num(len, LEN_LIMIT);
			put_crlf();
			repeat (len)
				put_byte(8'($urandom_range(255)));
			put_crlf();
		end
		r   = $urandom_range(99);
		pos = $urandom_range(scratch.size() - 1);
		if (r < 12) begin
			// corrupt one byte
			scratch[pos] = 8'($urandom_range(255));
			broken = 1'b1;
		end else if (r < 20) begin
			// cut short
			while (scratch.size() > pos + 1)
				void'(scratch.pop_back());
			broken = 1'b1;
		end else if (r < 26) begin
			// restart mid-command, leftover tail then parses as garbage
			for (int k = 0; k < pos; k++)
				push_data(scratch.pop_front());
			push_restart();
			broken = 1'b1;
		end else if (r < 30) begin
			// line noise ahead of the command
			repeat ($urandom_range(1, 4))
				scratch.push_front(8'($urandom_range(255)));
			broken = 1'b1;
		end
		flush(broken);
	endfunction

	// ------------------------------------------------------------------------
	// Idling plan: segments of SEG_BEATS accepted beats rotate through
	// no idling / sender gaps 66% / receiver stalls 66% / both at 13%
	// ------------------------------------------------------------------------
	function automatic bit roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit sender_gap();
		case ((cmd_beats / SEG_BEATS) % 4)
			1:       return roll(66);
			3:       return roll(13);
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_hold();
		case ((cmd_beats / SEG_BEATS) % 4)
			2:       return roll(66);
			3:       return roll(13);
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Driver: new beat only once the previous one was taken; a pending beat
	// keeps valid and payload steady regardless of cmd_stall
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : cmd_driver
		cmd_item_t it;
		if (arst_n && (!cmd_valid || cmd_beats == issued)) begin
			if (byte_stream.size() > 0 && !sender_gap()) begin
				it = byte_stream.pop_front();
				data_byte <= it.data;
				restart   <= it.rst;
				cmd_valid <= 1'b1;
				issued    <= issued + 1;
			end else
				cmd_valid <= 1'b0;
		end
	end

	// receiver stall; one long hold-off when the second quiet segment begins,
	// while the sender keeps offering so the pipe backs up into cmd_stall
	always @(negedge clk) begin
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!held_once && cmd_beats >= 4 * SEG_BEATS) begin
			held_once <= 1'b1;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else
			res_stall <= receiver_hold();
	end

	// ------------------------------------------------------------------------
	// Monitor: checks result beats against the oldest prediction and feeds
	// every accepted command beat into the predictor
	// ------------------------------------------------------------------------
	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : monitor
		parse_result_t exp_res;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (results_due.size() == 0) begin
					$error("result beat with none expected: kind %0d", kind);
					mismatches++;
				end else begin
					exp_res = results_due.pop_front();
					check_field("kind", exp_res.kind, kind);
					check_field("arg_byte", exp_res.data, arg_byte);
					check_field("arg_index", exp_res.arg, arg_index);
					check_field("byte_index", exp_res.pos, byte_index);
					check_field("last_arg", exp_res.last, last_arg);
					check_field("error_code", exp_res.err, error_code);
				end
			end
			if (cmd_valid && !cmd_stall) begin
				parse_byte(data_byte, restart);
				cmd_beats <= cmd_beats + 1;
			end
		end
	end

	// watchdog: any beat on either channel counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				quiet_count <= 0;
			else
				quiet_count <= quiet_count + 1;
			if (quiet_count >= WATCHDOG_MAX) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and run control
	// ------------------------------------------------------------------------
	initial begin
		int random_start;
		clear_parser();

		// restart while already idle
		push_restart();
		// empty commands, plain and negative zero
		put_line("*0");
		flush(1'b0);
		put_line("*-0");
		flush(1'b0);
		// one zero-length argument
		put_line("*1");
		put_line("$0");
		put_crlf();
		flush(1'b0);
		// extreme data bytes (CR inside data too), then a "-0" length
		put_line("*2");
		put_line("$3");
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(CHR_CR);
		put_crlf();
		put_line("$-0");
		put_crlf();
		flush(1'b0);
		// largest legal count and length, abandoned by restart mid-data
		put_line("*1024");
		put_line("$536870912");
		put_str("ab");
		flush(1'b1);
		// error cases; trailing bytes must be ignored until restart
		put_str("x*");
		flush(1'b1);
		put_line("*1");
		put_str("A$");
		flush(1'b1);
		put_str("*1A");
		flush(1'b1);
		put_str("*--");
		flush(1'b1);
		put_str("*1-");
		flush(1'b1);
		put_byte(CHR_STAR);
		put_byte(CHR_CR);
		flush(1'b1);
		put_str("*1025");
		flush(1'b1);
		put_str("*-1");
		flush(1'b1);
		put_line("*1");
		put_str("$536870913");
		flush(1'b1);
		put_str("*1");
		put_byte(CHR_CR);
		put_byte(CHR_CR);
		flush(1'b1);
		put_line("*1");
		put_str("$1");
		put_byte(CHR_CR);
		put_byte(CHR_CR);
		flush(1'b1);
		put_line("*1");
		put_line("$1");
		put_str("aX");
		flush(1'b1);
		put_line("*1");
		put_line("$1");
		put_str("a");
		put_byte(CHR_CR);
		put_byte(CHR_CR);
		flush(1'b1);

		random_start = byte_stream.size();
		while (byte_stream.size() < random_start + RANDOM_BEATS)
			gen_command();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all beats taken and every prediction checked
		while (byte_stream.size() != 0 || cmd_beats != issued || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && results_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
